// File: src/ultrasonic_echo_range_timer_top_macros.svh
// Assertion macros for the ultrasonic echo range timer.
// Used by the top level; needs clk and rst_n in the including scope.
`ifndef ULTRASONIC_ECHO_RANGE_TIMER_TOP_MACROS_SVH
`define ULTRASONIC_ECHO_RANGE_TIMER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define UERT_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("uert assertion failed");

// Next-cycle implication, checked out of reset.
`define UERT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("uert assertion failed");

`endif

// File: src/uert_pkg.sv
// Shared types and constants of the ultrasonic echo range timer.
// No dependencies.
package uert_pkg;

  localparam int COUNT_WRAP_DEF   = 9000;
  localparam int NUM_CHANNELS_DEF = 2;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_FIRE = 2'd1;
  localparam logic [1:0] REQ_ECHO = 2'd2;

  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_PULSES = 2'd2;

  localparam logic [15:0] SCALE_RST  = 16'd24176;
  localparam logic [19:0] OFFSET_RST = 20'd445645;
  localparam logic [7:0]  PULSES_RST = 8'd20;

  localparam int          DIST_W   = 13;
  localparam logic [12:0] DIST_MAX = 13'd8191;
  localparam int          Q_SHIFT  = 17;  // Q16 fraction plus the halving

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_COUNTING = 2'd1,
    MODE_RECEIVED = 2'd2
  } mode_t;

  typedef struct packed {
    logic [15:0] scale;
    logic [19:0] offset;
    logic [7:0]  pulses;
  } cfg_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] distance;
    logic              counting;
  } chan_stat_t;

endpackage

// File: src/uert_cfg.sv
// APB register file: scale, offset and echo threshold.
// Depends on uert_pkg.
module uert_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output uert_pkg::cfg_t    cfg
);

  logic [15:0] scale_r,  scale_nxt;
  logic [19:0] offset_r, offset_nxt;
  logic [7:0]  pulses_r, pulses_nxt;
  logic        wr_en;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    scale_nxt  = scale_r;
    offset_nxt = offset_r;
    pulses_nxt = pulses_r;
    if (wr_en) begin
      case (idx)
        uert_pkg::REG_SCALE:  scale_nxt  = pwdata[15:0];
        uert_pkg::REG_OFFSET: offset_nxt = pwdata[19:0];
        uert_pkg::REG_PULSES: pulses_nxt = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      uert_pkg::REG_SCALE:  prdata = {16'd0, scale_r};
      uert_pkg::REG_OFFSET: prdata = {12'd0, offset_r};
      uert_pkg::REG_PULSES: prdata = {24'd0, pulses_r};
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= uert_pkg::SCALE_RST;
      offset_r <= uert_pkg::OFFSET_RST;
      pulses_r <= uert_pkg::PULSES_RST;
    end else begin
      scale_r  <= scale_nxt;
      offset_r <= offset_nxt;
      pulses_r <= pulses_nxt;
    end
  end

  assign cfg.scale  = scale_r;
  assign cfg.offset = offset_r;
  assign cfg.pulses = pulses_r;

endmodule

// File: src/uert_chan.sv
// One sensor channel: mode, flight counter, pulse counter, latched distance.
// Depends on uert_pkg.
module uert_chan #(
  parameter int COUNT_WRAP = uert_pkg::COUNT_WRAP_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [1:0]          req,
  input  logic                sel,
  input  uert_pkg::cfg_t      cfg,
  output uert_pkg::chan_stat_t stat
);

  localparam int COUNT_W = $clog2(COUNT_WRAP);
  localparam int SUM_W   = COUNT_W + 17;
  localparam logic [COUNT_W-1:0] LAST_CNT = COUNT_W'(COUNT_WRAP - 1);

  uert_pkg::mode_t           mode_r,   mode_nxt;
  logic [COUNT_W-1:0]        flight_r, flight_nxt;
  logic [7:0]                pulse_r,  pulse_nxt;
  logic [uert_pkg::DIST_W-1:0] dist_r, dist_nxt;
  logic                      done;

  logic [7:0]                pulse_inc;
  logic [SUM_W-1:0]          sum;
  logic [SUM_W-1:0]          quo;
  logic [uert_pkg::DIST_W-1:0] dist_new;

  // Q16 multiply-add, drop fraction and halve, saturate to 13 bits
  assign sum       = SUM_W'(flight_r) * SUM_W'(cfg.scale) + SUM_W'(cfg.offset);
  assign quo       = sum >> uert_pkg::Q_SHIFT;
  assign dist_new  = (quo > SUM_W'(uert_pkg::DIST_MAX)) ? uert_pkg::DIST_MAX
                                                        : quo[uert_pkg::DIST_W-1:0];
  assign pulse_inc = pulse_r + 8'd1;

  always_comb begin
    mode_nxt   = mode_r;
    flight_nxt = flight_r;
    pulse_nxt  = pulse_r;
    dist_nxt   = dist_r;
    done       = 1'b0;
    if (step) begin
      case (req)
        uert_pkg::REQ_TICK: begin
          if (mode_r == uert_pkg::MODE_COUNTING) begin
            flight_nxt = (flight_r == LAST_CNT) ? '0 : flight_r + 1'b1;
          end else begin
            flight_nxt = '0;
          end
        end
        uert_pkg::REQ_FIRE: begin
          if (sel) mode_nxt = uert_pkg::MODE_COUNTING;
        end
        uert_pkg::REQ_ECHO: begin
          if (sel && mode_r == uert_pkg::MODE_COUNTING) begin
            if (pulse_inc > cfg.pulses) begin
              dist_nxt  = dist_new;
              mode_nxt  = uert_pkg::MODE_RECEIVED;
              pulse_nxt = 8'd0;
              done      = 1'b1;
            end else begin
              pulse_nxt = pulse_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= uert_pkg::MODE_IDLE;
      flight_r <= '0;
      pulse_r  <= '0;
      dist_r   <= '0;
    end else begin
      mode_r   <= mode_nxt;
      flight_r <= flight_nxt;
      pulse_r  <= pulse_nxt;
      dist_r   <= dist_nxt;
    end
  end

  assign stat.done     = done;
  assign stat.distance = dist_nxt;
  assign stat.counting = (mode_nxt == uert_pkg::MODE_COUNTING);

endmodule

// File: src/ultrasonic_echo_range_timer_top.sv
// Top level of the two-channel ultrasonic echo range timer.
// Depends on uert_pkg, uert_cfg, uert_chan and the assertion macro header.
//
//   channel | handshake         | payload
//   --------+-------------------+----------------------------------------------
//   in      | in_valid/in_ready | in_req_type, in_channel
//   out     | out_valid/ready   | out_done_res, out_distance, out_counting,
//           |                   | out_result_channel
//   cfg     | APB psel/penable  | paddr, pwdata, prdata (pready tied high)
//
// One item per cycle while out_ready is high; path: input register, then the
// per-channel update and the Q16 multiply-add into the result register.
// The multiply-add of flight count and scale sets the cycle length.
// Synchronous active-low reset returns modes, counters and distances to zero
// and the registers to their defaults; the block is ready right after reset.
// An output stall holds the result register; an empty input register still
// takes one more transfer, and in_ready drops once both registers are full.
`include "ultrasonic_echo_range_timer_top_macros.svh"

module ultrasonic_echo_range_timer_top #(
  parameter int COUNT_WRAP   = uert_pkg::COUNT_WRAP_DEF,
  parameter int NUM_CHANNELS = uert_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic        in_channel,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_done_res,
  output logic [12:0] out_distance,
  output logic        out_counting,
  output logic        out_result_channel,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  uert_pkg::cfg_t       cfg;
  uert_pkg::chan_stat_t stat [NUM_CHANNELS];
  uert_pkg::chan_stat_t sel_stat;

  // Input register
  logic       s1_v_r,   s1_v_nxt;
  logic [1:0] s1_req_r;
  logic       s1_ch_r;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic        done_r;
  logic [12:0] dist_r;
  logic        counting_r;
  logic        rch_r;

  logic adv;   // result register can take a new value
  logic step;  // input register item is processed this cycle
  logic ch_ok;

  uert_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign adv      = !out_valid_r || out_ready;
  assign step     = s1_v_r && adv;
  assign in_ready = !s1_v_r || adv;
  assign ch_ok    = int'(s1_ch_r) < NUM_CHANNELS;

  // Every channel sees every item: ticks advance counting channels and clear
  // the rest, fire and echo act only on the addressed one.
  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    uert_chan #(
      .COUNT_WRAP (COUNT_WRAP)
    ) u_chan (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (step),
      .req   (s1_req_r),
      .sel   (s1_ch_r == 1'(c)),
      .cfg   (cfg),
      .stat  (stat[c])
    );
  end

  // Pick the addressed channel's status; an absent channel reports zeros.
  always_comb begin
    sel_stat = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (ch_ok && s1_ch_r == 1'(c)) sel_stat = stat[c];
    end
  end

  // Hold the input register when the result side is stalled.
  assign s1_v_nxt      = in_ready ? in_valid : s1_v_r;
  assign out_valid_nxt = adv ? s1_v_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_req_r <= in_req_type;
      s1_ch_r  <= in_channel;
    end
    if (step) begin
      done_r     <= sel_stat.done;
      dist_r     <= sel_stat.distance;
      counting_r <= sel_stat.counting;
      rch_r      <= s1_ch_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_done_res       = done_r;
  assign out_distance       = dist_r;
  assign out_counting       = counting_r;
  assign out_result_channel = rch_r;

  // A completed measurement leaves the channel in received, never counting.
  `UERT_ASSERT_NOW(a_done_not_counting, out_valid_r && done_r, !counting_r)
  // A full pipeline facing a stalled consumer must refuse new transfers.
  `UERT_ASSERT_NOW(a_stall_blocks_input, s1_v_r && out_valid_r && !out_ready, !in_ready)
  // A tick never completes a measurement.
  `UERT_ASSERT_NEXT(a_tick_no_done, step && s1_req_r == uert_pkg::REQ_TICK, !done_r)
  // Each processed item produces a valid result in the next cycle.
  `UERT_ASSERT_NEXT(a_step_gives_result, step, out_valid_r && rch_r == $past(s1_ch_r))

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for the two-channel ultrasonic echo range timer.
// Needs uert_pkg and ultrasonic_echo_range_timer_top; a built-in predictor
// checks every result transfer against its own copy of modes and counters.
module tb_top;

  localparam int          COUNT_WRAP = uert_pkg::COUNT_WRAP_DEF;
  localparam int          NUM_CHAN   = uert_pkg::NUM_CHANNELS_DEF;
  localparam logic [1:0]  REQ_UNUSED = 2'd3;   // code the block only reports status for
  localparam int          MAX_CYCLES = 200000;

  // One result transfer, as seen on the out_ ports.
  typedef struct packed {
    logic        done;
    logic [12:0] distance;
    logic        counting;
    logic        channel;
  } status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = uert_pkg::REQ_TICK;
  logic        in_channel = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic        out_done_res;
  logic [12:0] out_distance;
  logic        out_counting;
  logic        out_result_channel;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of the ranging state and its registers.
  uert_pkg::mode_t chan_mode [NUM_CHAN];
  logic [13:0]     flight    [NUM_CHAN];
  logic [7:0]      pulses    [NUM_CHAN];
  logic [12:0]     last_dist [NUM_CHAN];
  logic [15:0]     scale_r  = uert_pkg::SCALE_RST;
  logic [19:0]     offset_r = uert_pkg::OFFSET_RST;
  logic [7:0]      thr_r    = uert_pkg::PULSES_RST;

  status_t pending_status [$];
  int      mismatch_cnt = 0;
  int      reqs_sent = 0;
  int      cycle_cnt = 0;
  int      stall_left = 0;
  bit      in_idle_en = 1'b1;
  bit      out_idle_en = 1'b1;

  ultrasonic_echo_range_timer_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_channel         (in_channel),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_done_res       (out_done_res),
    .out_distance       (out_distance),
    .out_counting       (out_counting),
    .out_result_channel (out_result_channel),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #6 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MAX_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_cnt, pending_status.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Draw a random wait; at least half the draws give no wait so that
  // back-to-back transfers stay common even with idling on.
  function automatic int draw_wait(input bit en);
    if (!en || $urandom_range(0, 1) == 0)
      return 0;
    return $urandom_range(0, 17);
  endfunction

  // Apply one request to the predictor and return the status it reports.
  function automatic status_t ranger_apply(input logic [1:0] req, input logic ch);
    status_t     st;
    logic [63:0] prod;
    st = '0;
    case (req)
      uert_pkg::REQ_TICK: begin
        // Advance every counting channel, clear every other one.
        for (int c = 0; c < NUM_CHAN; c++) begin
          if (chan_mode[c] == uert_pkg::MODE_COUNTING) begin
            if (int'(flight[c]) + 1 >= COUNT_WRAP)
              flight[c] = '0;
            else
              flight[c] = flight[c] + 14'd1;
          end else begin
            flight[c] = '0;
          end
        end
      end
      uert_pkg::REQ_FIRE: begin
        chan_mode[ch] = uert_pkg::MODE_COUNTING;
      end
      uert_pkg::REQ_ECHO: begin
        if (chan_mode[ch] == uert_pkg::MODE_COUNTING) begin
          pulses[ch] = pulses[ch] + 8'd1;
          if (pulses[ch] > thr_r) begin
            // Q16 multiply-add, drop the fraction, then halve.
            prod = 64'(flight[ch]) * 64'(scale_r) + 64'(offset_r);
            prod = (prod >> 16) >> 1;
            last_dist[ch] = (prod > 64'(uert_pkg::DIST_MAX)) ? uert_pkg::DIST_MAX
                                                             : prod[12:0];
            chan_mode[ch] = uert_pkg::MODE_RECEIVED;
            pulses[ch] = '0;
            st.done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    st.distance = last_dist[ch];
    st.counting = (chan_mode[ch] == uert_pkg::MODE_COUNTING);
    st.channel  = ch;
    return st;
  endfunction

  // Send one request; hold valid and payload until the transfer.
  task automatic send_req(input logic [1:0] req, input logic ch);
    int gap;
    gap = draw_wait(in_idle_en);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_channel  <= ch;
    do @(posedge clk); while (!in_ready);
    pending_status.push_back(ranger_apply(req, ch));
    reqs_sent++;
  endtask

  // Drop valid and let every outstanding result drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register over APB, read it back, and mirror it in the predictor.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    wait_idle();
    case (idx)
      uert_pkg::REG_SCALE:  mask = 32'h0000_FFFF;
      uert_pkg::REG_OFFSET: mask = 32'h000F_FFFF;
      default:              mask = 32'h0000_00FF;
    endcase
    // write: setup, then access
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // read back in the next transfer
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (value & mask)) begin
      $display("%0t: register %0d read back: expected %0h actual %0h",
               $time, idx, value & mask, prdata & mask);
      mismatch_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      uert_pkg::REG_SCALE:  scale_r  = value[15:0];
      uert_pkg::REG_OFFSET: offset_r = value[19:0];
      default:              thr_r    = value[7:0];
    endcase
  endtask

  task automatic set_ranger_config(input logic [15:0] scale, input logic [19:0] offset,
                                   input logic [7:0] thr);
    write_reg(uert_pkg::REG_SCALE, 32'(scale));
    write_reg(uert_pkg::REG_OFFSET, 32'(offset));
    write_reg(uert_pkg::REG_PULSES, 32'(thr));
  endtask

  // Result side: stall out_ready for a drawn number of cycles after each transfer.
  always @(posedge clk) begin : ready_ctl
    int w;
    if (rst_n) begin
      if (stall_left > 1) begin
        stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
        stall_left <= 0;
        out_ready  <= 1'b1;
      end else if (out_valid && out_ready) begin
        w = draw_wait(out_idle_en);
        if (w > 0) begin
          out_ready  <= 1'b0;
          stall_left <= w;
        end
      end
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Compare every result transfer with the oldest prediction.
  always @(posedge clk) begin : status_check
    status_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected result: expected none actual done=%0d dist=%0d cnt=%0d ch=%0d",
                 $time, out_done_res, out_distance, out_counting, out_result_channel);
        mismatch_cnt++;
      end else begin
        want = pending_status.pop_front();
        check_field("done_res", want.done, out_done_res);
        check_field("distance", want.distance, out_distance);
        check_field("counting", want.counting, out_counting);
        check_field("result_channel", want.channel, out_result_channel);
      end
    end
  end

  // Status on idle channels, the unused code, echoes that must be ignored,
  // and a second fire while already counting.
  task automatic test_basic_ops();
    send_req(uert_pkg::REQ_TICK, 1'b0);
    send_req(uert_pkg::REQ_TICK, 1'b1);
    send_req(REQ_UNUSED, 1'b0);
    send_req(uert_pkg::REQ_ECHO, 1'b0);
    send_req(uert_pkg::REQ_FIRE, 1'b0);
    send_req(uert_pkg::REQ_FIRE, 1'b0);
    send_req(uert_pkg::REQ_TICK, 1'b1);
    send_req(uert_pkg::REQ_TICK, 1'b0);
    send_req(uert_pkg::REQ_ECHO, 1'b1);
    send_req(uert_pkg::REQ_ECHO, 1'b0);
    send_req(REQ_UNUSED, 1'b1);
  endtask

  // Complete a measurement on a pulse count carried over from before, refire
  // from received, complete again, then echo a received channel.
  task automatic test_completion();
    set_ranger_config(uert_pkg::SCALE_RST, uert_pkg::OFFSET_RST, 8'd1);
    send_req(uert_pkg::REQ_ECHO, 1'b0);
    send_req(uert_pkg::REQ_FIRE, 1'b1);
    send_req(uert_pkg::REQ_TICK, 1'b0);
    send_req(uert_pkg::REQ_FIRE, 1'b0);
    send_req(uert_pkg::REQ_TICK, 1'b1);
    send_req(uert_pkg::REQ_ECHO, 1'b0);
    send_req(uert_pkg::REQ_ECHO, 1'b0);
    send_req(uert_pkg::REQ_ECHO, 1'b0);
    send_req(uert_pkg::REQ_ECHO, 1'b1);
    send_req(uert_pkg::REQ_ECHO, 1'b1);
    send_req(uert_pkg::REQ_TICK, 1'b0);
  endtask

  // With the top threshold the 8-bit pulse counter wraps and never completes;
  // lowering the threshold afterwards completes on the carried count.
  task automatic test_pulse_wrap();
    set_ranger_config(16'd1000, 20'd5000, 8'd255);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b1;
    send_req(uert_pkg::REQ_FIRE, 1'b1);
    repeat (260) send_req(uert_pkg::REQ_ECHO, 1'b1);
    write_reg(uert_pkg::REG_PULSES, 32'd2);
    send_req(uert_pkg::REQ_ECHO, 1'b1);
    send_req(uert_pkg::REQ_ECHO, 1'b1);
  endtask

  // Run the flight counter up a few dozen ticks, measure with the largest
  // factor and offset, then refire from received and measure again.
  task automatic test_max_factor();
    set_ranger_config(16'hFFFF, 20'hFFFFF, 8'd0);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    send_req(uert_pkg::REQ_FIRE, 1'b0);
    repeat (60) send_req(uert_pkg::REQ_TICK, 1'($urandom_range(0, 1)));
    send_req(uert_pkg::REQ_ECHO, 1'b0);
    send_req(uert_pkg::REQ_FIRE, 1'b0);
    send_req(uert_pkg::REQ_TICK, 1'b1);
    send_req(uert_pkg::REQ_ECHO, 1'b0);
  endtask

  // Mostly fire / tick / echo sequences on one channel with the other one
  // mixed in, plus some raw noise requests.
  task automatic run_random_items(input int n_items);
    int   first;
    int   steps;
    int   r;
    logic ch;
    first = reqs_sent;
    while (reqs_sent - first < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        send_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else begin
        ch = 1'($urandom_range(0, 1));
        send_req(uert_pkg::REQ_FIRE, ch);
        if ($urandom_range(0, 2) == 0)
          send_req(uert_pkg::REQ_FIRE, ~ch);
        steps = $urandom_range(4, int'(thr_r) + 12);
        repeat (steps) begin
          r = $urandom_range(0, 9);
          if (r < 4)
            send_req(uert_pkg::REQ_TICK, 1'($urandom_range(0, 1)));
          else if (r < 9)
            send_req(uert_pkg::REQ_ECHO, ch);
          else
            send_req(2'($urandom_range(1, 2)), ~ch);
        end
      end
    end
  endtask

  task automatic test_random();
    set_ranger_config(16'd0, 20'd0, 8'd0);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    run_random_items(25);
    set_ranger_config(16'hFFFF, 20'hFFFFF, 8'd5);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b0;
    run_random_items(25);
    set_ranger_config(uert_pkg::SCALE_RST, uert_pkg::OFFSET_RST, uert_pkg::PULSES_RST);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b1;
    run_random_items(25);
    set_ranger_config(16'($urandom_range(0, 65535)), 20'($urandom_range(0, 1048575)),
                      8'($urandom_range(0, 6)));
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    run_random_items(25);
  endtask

  initial begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      chan_mode[c] = uert_pkg::MODE_IDLE;
      flight[c]    = '0;
      pulses[c]    = '0;
      last_dist[c] = '0;
    end
    // hold reset, then release at an edge
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_completion();
    test_pulse_wrap();
    test_max_factor();
    test_random();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
